/* rtl/bpc_pkg.sv */
// ---------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the button press classifier
// Phase and event codes, operation codes, register indexes and defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

  // Field widths
  localparam int OP_W    = 2;
  localparam int SW_W    = 3;
  localparam int EV_W    = 3;
  localparam int TIMER_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Default switch count
  localparam int NUM_SWITCHES_DEF = 5;

  // Register reset values
  localparam logic [TIMER_W-1:0] DEBOUNCE_DEF   = 16'd10;
  localparam logic [TIMER_W-1:0] SHORT_LIM_DEF  = 16'd1000;
  localparam logic [TIMER_W-1:0] LONG_LIM_DEF   = 16'd2000;
  localparam logic [TIMER_W-1:0] TIMER_MAX      = 16'hFFFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIM  = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_POLL  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_SEEN       = 3'd1,
    PH_DEBOUNCE   = 3'd2,
    PH_CONFIRM    = 3'd3,
    PH_HOLD       = 3'd4,
    PH_HELD_LONG  = 3'd5,
    PH_REL_BOUNCE = 3'd6
  } phase_t;

  typedef enum logic [EV_W-1:0] {
    EV_IDLE     = 3'd0,
    EV_PRESSED  = 3'd1,
    EV_SHORT    = 3'd2,
    EV_LONG     = 3'd3,
    EV_RELEASED = 3'd4
  } event_t;

  // Per-switch state
  typedef struct packed {
    phase_t               phase;
    logic [TIMER_W-1:0]   elapsed;
    event_t               evt;
  } sw_state_t;

  // Timing registers
  typedef struct packed {
    logic [TIMER_W-1:0] debounce;
    logic [TIMER_W-1:0] short_lim;
    logic [TIMER_W-1:0] long_lim;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/bpc_if.sv */
// ---------------------------------------------------------------------------
// bpc_if: valid/ready channels of the button press classifier
// Input channel carries operations, result channel carries switch events.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bpc_in_if;
  import bpc_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [SW_W-1:0]   switch_index;
  logic              level_high;

  modport source (output valid, output op, output switch_index, output level_high,
                  input ready);
  modport sink   (input valid, input op, input switch_index, input level_high,
                  output ready);
endinterface

interface bpc_out_if;
  import bpc_pkg::*;

  logic              valid;
  logic              ready;
  logic [SW_W-1:0]   switch_id;
  logic [EV_W-1:0]   event_code;

  modport source (output valid, output switch_id, output event_code, input ready);
  modport sink   (input valid, input switch_id, input event_code, output ready);
endinterface

`default_nettype wire

/* rtl/bpc_step.sv */
// ---------------------------------------------------------------------------
// bpc_step: one poll step of a switch's debounce and classify machine
// Combinational next state of phase, timer and sticky event.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpc_step (
  input  bpc_pkg::sw_state_t cur,
  input  bpc_pkg::cfg_t      cfg,
  input  logic               pressed,
  output bpc_pkg::sw_state_t nxt
);
  import bpc_pkg::*;

  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      PH_SEEN: begin
        nxt.elapsed = '0;
        nxt.phase   = PH_DEBOUNCE;
      end
      PH_DEBOUNCE: begin
        if (cur.elapsed >= cfg.debounce) begin
          nxt.phase = pressed ? PH_CONFIRM : PH_IDLE;
        end else if (!pressed) begin
          nxt.phase = PH_IDLE;
        end
      end
      PH_CONFIRM: begin
        nxt.elapsed = '0;
        nxt.phase   = PH_HOLD;
        nxt.evt     = EV_PRESSED;
      end
      PH_HOLD: begin
        // release classifies by hold time; holding past the long limit reports early
        if (!pressed) begin
          nxt.evt     = (cur.elapsed < cfg.short_lim) ? EV_SHORT : EV_LONG;
          nxt.elapsed = '0;
          nxt.phase   = PH_REL_BOUNCE;
        end else if (cur.elapsed > cfg.long_lim) begin
          nxt.evt   = EV_LONG;
          nxt.phase = PH_HELD_LONG;
        end
      end
      PH_HELD_LONG: begin
        if (!pressed) begin
          nxt.elapsed = '0;
          nxt.phase   = PH_REL_BOUNCE;
        end
      end
      PH_REL_BOUNCE: begin
        if (cur.elapsed >= cfg.debounce) begin
          nxt.evt   = EV_RELEASED;
          nxt.phase = PH_IDLE;
        end
      end
      default: begin
        // idle and the unused code
        nxt.phase = pressed ? PH_SEEN : PH_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/button_press_classifier_core.sv */
// ---------------------------------------------------------------------------
// button_press_classifier_core: debouncer and short/long press classifier
//
// Input channel (in_ch): op tick advances every switch timer, op poll steps
// the addressed switch's machine with its pin level (low = pressed), op
// clear returns the addressed switch's sticky event to idle. Unused ops and
// out-of-range switches are consumed without a result.
// Result channel (out_ch): one transfer per valid poll or clear, carrying the
// switch and its event after the update. Ticks produce nothing.
// The user must write timing registers on the cfg_ port only while the block
// is idle; the block itself does not enforce this. Items pass the input register,
// then the result register. Throughput: one item per cycle while the receiver
// does not stall, set by the single state-update stage between the registers.
// Reset (synchronous, rst_n low): all switches idle, timers zero, events
// idle, registers at their defaults, both pipeline registers empty.
// When the receiver stalls, the held result blocks the update stage and
// in_ch.ready drops once the input register is also full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_press_classifier_core #(
  parameter int NUM_SWITCHES = bpc_pkg::NUM_SWITCHES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  bpc_in_if.sink                              in_ch,
  bpc_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import bpc_pkg::*;

  localparam int IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

  // Timing registers
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce  <= DEBOUNCE_DEF;
      cfg_r.short_lim <= SHORT_LIM_DEF;
      cfg_r.long_lim  <= LONG_LIM_DEF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:  cfg_r.debounce  <= cfg_wdata;
        CFG_SHORT_LIM: cfg_r.short_lim <= cfg_wdata;
        CFG_LONG_LIM:  cfg_r.long_lim  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  logic            in_valid_r;
  logic [OP_W-1:0] op_r;
  logic [SW_W-1:0] idx_r;
  logic            level_r;

  // Result register
  logic            out_valid_r;
  logic [SW_W-1:0] out_id_r;
  logic [EV_W-1:0] out_code_r;

  logic advance;
  logic proc;
  logic in_ready;

  assign advance  = !out_valid_r || out_ch.ready;
  assign proc     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      op_r    <= in_ch.op;
      idx_r   <= in_ch.switch_index;
      level_r <= in_ch.level_high;
    end
  end

  // Switch state
  sw_state_t st_r   [NUM_SWITCHES];
  sw_state_t st_nxt [NUM_SWITCHES];

  logic [IDX_W-1:0] sel;
  logic             in_range;
  sw_state_t        cur_st;
  sw_state_t        step_st;

  assign sel      = IDX_W'(idx_r);
  assign in_range = ({29'd0, idx_r} < 32'(NUM_SWITCHES));

  always_comb begin
    cur_st = '0;
    if (in_range) begin
      cur_st = st_r[sel];
    end
  end

  bpc_step u_step (
    .cur     (cur_st),
    .cfg     (cfg_r),
    .pressed (!level_r),
    .nxt     (step_st)
  );

  // State update and result selection
  logic            res_valid;
  logic [EV_W-1:0] res_code;

  always_comb begin
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      st_nxt[i] = st_r[i];
    end
    res_valid = 1'b0;
    res_code  = EV_IDLE;
    if (proc) begin
      case (op_r)
        OP_TICK: begin
          // timers saturate one past the long limit
          for (int i = 0; i < NUM_SWITCHES; i++) begin
            if (st_r[i].elapsed <= cfg_r.long_lim && st_r[i].elapsed != TIMER_MAX) begin
              st_nxt[i].elapsed = st_r[i].elapsed + 16'd1;
            end
          end
        end
        OP_POLL: begin
          if (in_range) begin
            st_nxt[sel] = step_st;
            res_valid   = 1'b1;
            res_code    = step_st.evt;
          end
        end
        OP_CLEAR: begin
          if (in_range) begin
            st_nxt[sel].evt = EV_IDLE;
            res_valid       = 1'b1;
            res_code        = EV_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SWITCHES; i++) begin
        st_r[i].phase   <= PH_IDLE;
        st_r[i].elapsed <= '0;
        st_r[i].evt     <= EV_IDLE;
      end
    end else begin
      for (int i = 0; i < NUM_SWITCHES; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_id_r   <= idx_r;
      out_code_r <= res_code;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.switch_id  = out_id_r;
  assign out_ch.event_code = out_code_r;

  // Checks
  a_tick_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && op_r == OP_TICK) |=> !out_valid_r)
    else $error("tick produced a result");

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && op_r == OP_CLEAR && in_range) |=> (out_valid_r && out_code_r == EV_IDLE))
    else $error("clear did not report idle");

  a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_code_r <= EV_RELEASED))
    else $error("illegal event code");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire
